// ----- design/sfa_pkg.sv -----
// Shared types and constants of the segregated-fit heap allocator.
`timescale 1ns / 1ps
package sfa_pkg;

  localparam int ADDR_W  = 35;
  localparam int LIMIT_W = 17;

  localparam logic [31:0] USED_MARK     = 32'hDDDDDDDF;
  localparam logic [31:0] MIN_REMAINDER = 32'd16;
  localparam logic [16:0] MIN_REQUEST   = 17'd8;
  localparam logic [16:0] HEAP_BASE     = 17'd8;
  localparam logic [16:0] LIMIT_RST     = 17'd65536;
  localparam logic [16:0] BYTE_CAP      = 17'd65536;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] request_bytes;
    logic [15:0] free_offset;
  } req_t;

  typedef struct packed {
    logic        valid;
    logic [15:0] user_offset;
    logic        ok;
  } res_t;

endpackage

// ----- design/sfa_if.sv -----
// Request, response and configuration channel interfaces.
`timescale 1ns / 1ps
interface sfa_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] request_bytes;
  logic [15:0] free_offset;
  modport source (output valid, kind, request_bytes, free_offset, input ready);
  modport sink (input valid, kind, request_bytes, free_offset, output ready);
endinterface

interface sfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] user_offset;
  logic        ok;
  modport source (output valid, user_offset, ok, input ready);
  modport sink (input valid, user_offset, ok, output ready);
endinterface

interface sfa_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] heap_limit;
  modport source (output valid, heap_limit, input ready);
  modport sink (input valid, heap_limit, output ready);
endinterface

// ----- design/sfa_ram.sv -----
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module sfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem_q[addr_i];
      end
    end
  end

endmodule

// ----- design/sfa_seq.sv -----
// Request sequencer: bucket heads, heap top and tag read-modify-write steps.
`timescale 1ns / 1ps
module sfa_seq #(
  parameter int HEAP_WORDS = 16384,
  parameter int BUCKETS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  sfa_pkg::req_t                 req_i,
  output logic                          req_ready_o,
  input  logic [sfa_pkg::LIMIT_W-1:0]   heap_limit_i,
  output sfa_pkg::res_t                 res_o,
  input  logic                          res_ready_i,
  output logic                          mem_en_o,
  output logic                          mem_we_o,
  output logic [$clog2(HEAP_WORDS)-1:0] mem_addr_o,
  output logic [31:0]                   mem_wdata_o,
  input  logic [31:0]                   mem_rdata_i
);

  localparam int AW         = sfa_pkg::ADDR_W;
  localparam int IDX_W      = $clog2(HEAP_WORDS);
  localparam int BKT_W      = $clog2(BUCKETS);
  localparam int WALK_LIMIT = HEAP_WORDS / 4 + 1;
  localparam int SW         = $clog2(WALK_LIMIT + 1);
  localparam int CAP_INT    = (HEAP_WORDS * 4 < 65536) ? HEAP_WORDS * 4 : 65536;
  localparam logic [16:0] CAP17 = 17'(CAP_INT);

  localparam logic [5:0] S_IDLE   = 6'd0;
  localparam logic [5:0] S_AINIT  = 6'd1;
  localparam logic [5:0] S_ABKT   = 6'd2;
  localparam logic [5:0] S_ACHK   = 6'd3;
  localparam logic [5:0] S_AM     = 6'd4;
  localparam logic [5:0] S_ANX    = 6'd5;
  localparam logic [5:0] S_AUSED  = 6'd6;
  localparam logic [5:0] S_AUSED2 = 6'd7;
  localparam logic [5:0] S_AAPP   = 6'd8;
  localparam logic [5:0] S_AAPP2  = 6'd9;
  localparam logic [5:0] S_U0     = 6'd10;
  localparam logic [5:0] S_U1     = 6'd11;
  localparam logic [5:0] S_U2     = 6'd12;
  localparam logic [5:0] S_U3     = 6'd13;
  localparam logic [5:0] S_F0     = 6'd14;
  localparam logic [5:0] S_F1     = 6'd15;
  localparam logic [5:0] S_F2     = 6'd16;
  localparam logic [5:0] S_F3     = 6'd17;
  localparam logic [5:0] S_F4     = 6'd18;
  localparam logic [5:0] S_M0     = 6'd19;
  localparam logic [5:0] S_M1     = 6'd20;
  localparam logic [5:0] S_M2     = 6'd21;
  localparam logic [5:0] S_M3     = 6'd22;
  localparam logic [5:0] S_M4     = 6'd23;
  localparam logic [5:0] S_R0     = 6'd24;
  localparam logic [5:0] S_R1     = 6'd25;
  localparam logic [5:0] S_R2     = 6'd26;
  localparam logic [5:0] S_R3     = 6'd27;
  localparam logic [5:0] S_R4     = 6'd28;
  localparam logic [5:0] S_R5     = 6'd29;
  localparam logic [5:0] S_R6     = 6'd30;
  localparam logic [5:0] S_R7     = 6'd31;
  localparam logic [5:0] S_R8     = 6'd32;
  localparam logic [5:0] S_R9     = 6'd33;
  localparam logic [5:0] S_R10    = 6'd34;
  localparam logic [5:0] S_DONE   = 6'd35;

  function automatic logic [BKT_W-1:0] bkt_free(input logic [31:0] m);
    logic [5:0] p;
    p = '0;
    for (int i = 1; i < 32; i++) begin
      if (m[i]) begin
        p = 6'(i);
      end
    end
    if (p < 6'd3) begin
      return '0;
    end else if (int'(p) < 3 + BUCKETS) begin
      return BKT_W'(p - 6'd3);
    end else begin
      return BKT_W'(BUCKETS - 1);
    end
  endfunction

  function automatic logic [4:0] ceil_log2(input logic [16:0] n);
    logic [16:0] v;
    logic [4:0]  p;
    v = n - 17'd1;
    p = '0;
    for (int i = 1; i < 17; i++) begin
      if (v[i]) begin
        p = 5'(i);
      end
    end
    return p + 5'd1;
  endfunction

  function automatic logic [BKT_W-1:0] bkt_req(input logic [16:0] n);
    logic [4:0] p;
    p = ceil_log2(n);
    if (p <= 5'd3) begin
      return '0;
    end else if (int'(p) < 3 + BUCKETS) begin
      return BKT_W'(p - 5'd3);
    end else begin
      return BKT_W'(BUCKETS - 1);
    end
  endfunction

  logic [5:0]       state_q, state_d, sret_q, sret_d, mret_q, mret_d;
  logic [16:0]      n_q, n_d, heap_top_q, heap_top_d;
  logic [BKT_W-1:0] bkt_q, bkt_d, ub_q, ub_d;
  logic [SW-1:0]    steps_q, steps_d;
  logic [31:0]      cur_q, cur_d, m_q, m_d, use_q, use_d, c_q, c_d;
  logic [31:0]      prev_q, prev_d, next_q, next_d, fm_q, fm_d, ls_q, ls_d, rs_q, rs_d;
  logic [AW-1:0]    ua_q, ua_d, fa_q, fa_d, ml_q, ml_d, mr_q, mr_d;
  logic [15:0]      fnext_q, fnext_d, res_user_q, res_user_d;
  logic             res_ok_q, res_ok_d, rd_ok_q, rd_ok_d;
  logic [15:0]      heads_q [BUCKETS];

  logic             hd_we;
  logic [BKT_W-1:0] hd_widx, fb;
  logic [15:0]      hd_wdata;
  logic             mem_go, mem_we, inr;
  logic [AW-1:0]    mem_addr;
  logic [31:0]      mem_wdata, rdv, mw;
  logic [16:0]      nraw, sz, lim;
  logic [17:0]      app_sum;
  logic [AW-1:0]    end_a;

  assign rdv     = rd_ok_q ? mem_rdata_i : '0;
  assign mw      = {1'b0, rdv[31:1]};
  assign fb      = bkt_free(fm_q);
  assign nraw    = (req_i.request_bytes < 16'(sfa_pkg::MIN_REQUEST)) ?
                   sfa_pkg::MIN_REQUEST : {1'b0, req_i.request_bytes};
  assign sz      = 17'd1 << ceil_log2(n_q);
  assign lim     = (heap_limit_i < CAP17) ? heap_limit_i : CAP17;
  assign app_sum = 18'(heap_top_q) + 18'(sz) + 18'd8;
  assign end_a   = AW'(c_q) + AW'(mw) + AW'(8);
  assign inr     = mem_addr[AW-1:2] < (AW-2)'(HEAP_WORDS);

  always_comb begin
    state_d    = state_q;
    sret_d     = sret_q;
    mret_d     = mret_q;
    n_d        = n_q;
    heap_top_d = heap_top_q;
    bkt_d      = bkt_q;
    ub_d       = ub_q;
    steps_d    = steps_q;
    cur_d      = cur_q;
    m_d        = m_q;
    use_d      = use_q;
    c_d        = c_q;
    prev_d     = prev_q;
    next_d     = next_q;
    fm_d       = fm_q;
    ls_d       = ls_q;
    rs_d       = rs_q;
    ua_d       = ua_q;
    fa_d       = fa_q;
    ml_d       = ml_q;
    mr_d       = mr_q;
    fnext_d    = fnext_q;
    res_user_d = res_user_q;
    res_ok_d   = res_ok_q;
    rd_ok_d    = rd_ok_q;
    hd_we      = 1'b0;
    hd_widx    = '0;
    hd_wdata   = '0;
    mem_go     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = '0;
    mem_wdata  = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        res_user_d  = '0;
        res_ok_d    = 1'b0;
        if (req_valid_i) begin
          if (req_i.kind == sfa_pkg::KIND_ALLOC) begin
            n_d = (nraw + 17'd3) & ~17'd3;
            state_d = (req_i.request_bytes == 16'd0) ? S_DONE : S_AINIT;
          end else begin
            c_d = {16'b0, req_i.free_offset - 16'd4};
            if (req_i.free_offset[1:0] != 2'b00 || req_i.free_offset < 16'd12) begin
              state_d = S_DONE;
            end else begin
              state_d = S_R0;
            end
          end
        end
      end
      S_AINIT: begin
        bkt_d   = bkt_req(n_q);
        state_d = S_ABKT;
      end
      S_ABKT: begin
        cur_d   = {16'b0, heads_q[bkt_q]};
        steps_d = '0;
        state_d = S_ACHK;
      end
      S_ACHK: begin
        if (cur_q == 32'd0 || steps_q >= SW'(WALK_LIMIT)) begin
          if (bkt_q == BKT_W'(BUCKETS - 1)) begin
            state_d = S_AAPP;
          end else begin
            bkt_d   = bkt_q + 1'b1;
            state_d = S_ABKT;
          end
        end else begin
          mem_go   = 1'b1;
          mem_addr = AW'(cur_q);
          state_d  = S_AM;
        end
      end
      S_AM: begin
        m_d = mw;
        if (mw >= {15'b0, n_q}) begin
          use_d   = (mw - {15'b0, n_q} < sfa_pkg::MIN_REMAINDER) ? mw : {15'b0, n_q};
          ua_d    = AW'(cur_q);
          ub_d    = bkt_q;
          sret_d  = S_AUSED;
          state_d = S_U0;
        end else begin
          mem_go   = 1'b1;
          mem_addr = AW'(cur_q) + AW'(8);
          state_d  = S_ANX;
        end
      end
      S_ANX: begin
        cur_d   = rdv;
        steps_d = steps_q + 1'b1;
        state_d = S_ACHK;
      end
      S_AUSED: begin
        mem_go    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = AW'(cur_q);
        mem_wdata = {use_q[30:0], 1'b1};
        state_d   = S_AUSED2;
      end
      S_AUSED2: begin
        mem_go     = 1'b1;
        mem_we     = 1'b1;
        mem_addr   = AW'(cur_q) + AW'(4) + AW'(use_q);
        mem_wdata  = sfa_pkg::USED_MARK;
        res_user_d = cur_q[15:0] + 16'd4;
        res_ok_d   = 1'b1;
        if (use_q != m_q) begin
          fa_d    = AW'(cur_q) + AW'(use_q) + AW'(8);
          fm_d    = m_q - use_q - 32'd8;
          sret_d  = S_DONE;
          state_d = S_F0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_AAPP: begin
        if (app_sum >= {1'b0, lim}) begin
          state_d = S_DONE;
        end else begin
          c_d        = {15'b0, heap_top_q};
          use_d      = {15'b0, sz};
          heap_top_d = app_sum[16:0];
          mem_go     = 1'b1;
          mem_we     = 1'b1;
          mem_addr   = AW'(heap_top_q);
          mem_wdata  = {14'b0, sz, 1'b1};
          state_d    = S_AAPP2;
        end
      end
      S_AAPP2: begin
        mem_go     = 1'b1;
        mem_we     = 1'b1;
        mem_addr   = AW'(c_q) + AW'(4) + AW'(use_q);
        mem_wdata  = sfa_pkg::USED_MARK;
        res_user_d = c_q[15:0] + 16'd4;
        res_ok_d   = 1'b1;
        state_d    = S_DONE;
      end
      S_U0: begin
        mem_go   = 1'b1;
        mem_addr = ua_q + AW'(4);
        state_d  = S_U1;
      end
      S_U1: begin
        prev_d   = rdv;
        mem_go   = 1'b1;
        mem_addr = ua_q + AW'(8);
        state_d  = S_U2;
      end
      S_U2: begin
        next_d = rdv;
        if (prev_q == 32'd0) begin
          hd_we    = 1'b1;
          hd_widx  = ub_q;
          hd_wdata = rdv[15:0];
        end else begin
          mem_go    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = AW'(prev_q) + AW'(8);
          mem_wdata = rdv;
        end
        state_d = S_U3;
      end
      S_U3: begin
        if (next_q != 32'd0) begin
          mem_go    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = AW'(next_q) + AW'(4);
          mem_wdata = prev_q;
        end
        state_d = sret_q;
      end
      S_F0: begin
        fnext_d   = heads_q[fb];
        hd_we     = 1'b1;
        hd_widx   = fb;
        hd_wdata  = fa_q[15:0];
        mem_go    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = fa_q;
        mem_wdata = {fm_q[30:0], 1'b0};
        state_d   = S_F1;
      end
      S_F1: begin
        if (fnext_q != 16'd0) begin
          mem_go    = 1'b1;
          mem_we    = 1'b1;
          mem_addr  = AW'(fnext_q) + AW'(4);
          mem_wdata = fa_q[31:0];
        end
        state_d = S_F2;
      end
      S_F2: begin
        mem_go    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = fa_q + AW'(4);
        mem_wdata = '0;
        state_d   = S_F3;
      end
      S_F3: begin
        mem_go    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = fa_q + AW'(8);
        mem_wdata = {16'b0, fnext_q};
        state_d   = S_F4;
      end
      S_F4: begin
        mem_go    = 1'b1;
        mem_we    = 1'b1;
        mem_addr  = fa_q + AW'(4) + AW'(fm_q);
        mem_wdata = {fm_q[30:0], 1'b0};
        state_d   = sret_q;
      end
      S_M0: begin
        mem_go   = 1'b1;
        mem_addr = ml_q;
        state_d  = S_M1;
      end
      S_M1: begin
        ls_d     = mw;
        mem_go   = 1'b1;
        mem_addr = mr_q;
        state_d  = S_M2;
      end
      S_M2: begin
        rs_d    = mw;
        ua_d    = ml_q;
        ub_d    = bkt_free(ls_q);
        sret_d  = S_M3;
        state_d = S_U0;
      end
      S_M3: begin
        ua_d    = mr_q;
        ub_d    = bkt_free(rs_q);
        sret_d  = S_M4;
        state_d = S_U0;
      end
      S_M4: begin
        fa_d    = ml_q;
        fm_d    = ls_q + rs_q + 32'd8;
        sret_d  = mret_q;
        state_d = S_F0;
      end
      S_R0: begin
        mem_go   = 1'b1;
        mem_addr = AW'(c_q);
        state_d  = S_R1;
      end
      S_R1: begin
        m_d = mw;
        if (!rdv[0] || mw < 32'd8 || end_a > AW'(heap_top_q)) begin
          state_d = S_DONE;
        end else begin
          mem_go   = 1'b1;
          mem_addr = AW'(c_q) + AW'(4) + AW'(mw);
          state_d  = S_R2;
        end
      end
      S_R2: begin
        if (rdv != sfa_pkg::USED_MARK) begin
          state_d = S_DONE;
        end else begin
          fa_d    = AW'(c_q);
          fm_d    = m_q;
          sret_d  = S_R3;
          state_d = S_F0;
        end
      end
      S_R3: begin
        if (c_q >= 32'd12) begin
          mem_go   = 1'b1;
          mem_addr = AW'(c_q) - AW'(4);
          state_d  = S_R4;
        end else begin
          state_d = S_R5;
        end
      end
      S_R4: begin
        if (!rdv[0] && (mw + 32'd16 <= c_q)) begin
          ml_d    = AW'(c_q - mw - 32'd8);
          mr_d    = AW'(c_q);
          c_d     = c_q - mw - 32'd8;
          mret_d  = S_R5;
          state_d = S_M0;
        end else begin
          state_d = S_R5;
        end
      end
      S_R5: begin
        mem_go   = 1'b1;
        mem_addr = AW'(c_q);
        state_d  = S_R6;
      end
      S_R6: begin
        if (end_a < AW'(heap_top_q)) begin
          mr_d     = end_a;
          mem_go   = 1'b1;
          mem_addr = end_a;
          state_d  = S_R7;
        end else begin
          state_d = S_R8;
        end
      end
      S_R7: begin
        if (!rdv[0]) begin
          ml_d    = AW'(c_q);
          mret_d  = S_R8;
          state_d = S_M0;
        end else begin
          state_d = S_R8;
        end
      end
      S_R8: begin
        mem_go   = 1'b1;
        mem_addr = AW'(c_q);
        state_d  = S_R9;
      end
      S_R9: begin
        if (end_a == AW'(heap_top_q)) begin
          heap_top_d = c_q[16:0];
          ua_d       = AW'(c_q);
          ub_d       = bkt_free(mw);
          sret_d     = S_R10;
          state_d    = S_U0;
        end else begin
          state_d = S_R10;
        end
      end
      S_R10: begin
        res_user_d = '0;
        res_ok_d   = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (mem_go && !mem_we) begin
      rd_ok_d = inr;
    end
  end

  assign mem_en_o    = mem_go && inr;
  assign mem_we_o    = mem_we;
  assign mem_addr_o  = mem_addr[IDX_W+1:2];
  assign mem_wdata_o = mem_wdata;

  assign res_o.valid       = (state_q == S_DONE);
  assign res_o.user_offset = res_user_q;
  assign res_o.ok          = res_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      heap_top_q <= sfa_pkg::HEAP_BASE;
      for (int i = 0; i < BUCKETS; i++) begin
        heads_q[i] <= '0;
      end
    end else begin
      state_q    <= state_d;
      heap_top_q <= heap_top_d;
      if (hd_we) begin
        heads_q[hd_widx] <= hd_wdata;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sret_q     <= sret_d;
    mret_q     <= mret_d;
    n_q        <= n_d;
    bkt_q      <= bkt_d;
    ub_q       <= ub_d;
    steps_q    <= steps_d;
    cur_q      <= cur_d;
    m_q        <= m_d;
    use_q      <= use_d;
    c_q        <= c_d;
    prev_q     <= prev_d;
    next_q     <= next_d;
    fm_q       <= fm_d;
    ls_q       <= ls_d;
    rs_q       <= rs_d;
    ua_q       <= ua_d;
    fa_q       <= fa_d;
    ml_q       <= ml_d;
    mr_q       <= mr_d;
    fnext_q    <= fnext_d;
    res_user_q <= res_user_d;
    res_ok_q   <= res_ok_d;
    rd_ok_q    <= rd_ok_d;
  end

  a_top_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_top_q >= sfa_pkg::HEAP_BASE)
    else $error("heap top fell below the heap base");

  a_top_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_top_q <= CAP17)
    else $error("heap top passed the byte capacity");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.ok |-> res_o.user_offset == 16'd0)
    else $error("failed result carries a nonzero offset");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !mem_we_o && !hd_we)
    else $error("state written while idle");

  a_accept_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> state_q != S_IDLE)
    else $error("accepted request left the sequencer idle");

endmodule

// ----- design/segregated_fit_heap_allocator_top.sv -----
// Top level of the segregated-fit heap allocator.
`timescale 1ns / 1ps
// Usage:
//   req  : one allocate (kind 0, request_bytes) or free (kind 1, free_offset)
//          request, taken on valid && ready; ready is high only while the
//          sequencer is idle.
//   rsp  : one result per request (user_offset, ok) from an output register;
//          the next request is taken while a result still waits there.
//   cfg  : heap_limit write, always ready; write only while idle.
// The sequencer works through the single tag memory port, one access per
// cycle with a registered read. An append follows a walk of the buckets
// visited; reuse of a free chunk walks the buckets visited and the chunks
// passed over, and files a split remainder when one is left. A performed
// free merges with free neighbours and gives space back at the heap top
// where it can; a free rejected on its tags answers after reading them.
// A zero-size allocate or a malformed free answers without a memory access.
// Reset empties all bucket lists, sets the heap top to 8 and the limit to
// 65536; the tag memory needs no clearing pass. A stalled receiver holds the
// result in the output register and the sequencer waits in its done state.
module segregated_fit_heap_allocator_top #(
  parameter int HEAP_WORDS = 16384,
  parameter int BUCKETS    = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  sfa_req_if.sink   req,
  sfa_rsp_if.source rsp,
  sfa_cfg_if.sink   cfg
);

  localparam int IDX_W = $clog2(HEAP_WORDS);

  logic [sfa_pkg::LIMIT_W-1:0] heap_limit_q;
  sfa_pkg::req_t               seq_req;
  sfa_pkg::res_t               seq_res;
  logic                        res_ready;
  logic                        rsp_valid_q;
  logic [15:0]                 rsp_user_q;
  logic                        rsp_ok_q;
  logic                        mem_en, mem_we;
  logic [IDX_W-1:0]            mem_addr;
  logic [31:0]                 mem_wdata, mem_rdata;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_limit_q <= sfa_pkg::LIMIT_RST;
    end else if (cfg.valid) begin
      heap_limit_q <= cfg.heap_limit;
    end
  end

  assign seq_req.kind          = req.kind;
  assign seq_req.request_bytes = req.request_bytes;
  assign seq_req.free_offset   = req.free_offset;

  assign res_ready = !rsp_valid_q || rsp.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (seq_res.valid && res_ready) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_res.valid && res_ready) begin
      rsp_user_q <= seq_res.user_offset;
      rsp_ok_q   <= seq_res.ok;
    end
  end

  assign rsp.valid       = rsp_valid_q;
  assign rsp.user_offset = rsp_user_q;
  assign rsp.ok          = rsp_ok_q;

  sfa_seq #(
    .HEAP_WORDS (HEAP_WORDS),
    .BUCKETS    (BUCKETS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req.valid),
    .req_i        (seq_req),
    .req_ready_o  (req.ready),
    .heap_limit_i (heap_limit_q),
    .res_o        (seq_res),
    .res_ready_i  (res_ready),
    .mem_en_o     (mem_en),
    .mem_we_o     (mem_we),
    .mem_addr_o   (mem_addr),
    .mem_wdata_o  (mem_wdata),
    .mem_rdata_i  (mem_rdata)
  );

  sfa_ram #(
    .WIDTH (32),
    .DEPTH (HEAP_WORDS)
  ) u_tags (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule
